// File: hw/rtl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared constants and types for the pin pulse monitor.
// ----------------------------------------------------------------------------
package ppm_pkg;

	localparam int TIME_W   = 32;
	localparam int DL_W     = TIME_W + 1;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int EVQ_DEPTH  = 4;
	localparam int EVQ_PTR_W  = 2;
	localparam int EVQ_CNT_W  = 3;
	localparam int MAX_EV     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SETTLE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 2'd2;

	localparam logic [TIME_W-1:0] SETTLE_RST     = 32'd50;
	localparam logic [TIME_W-1:0] LONG_PULSE_RST = 32'd1000;

	typedef enum logic [2:0] {
		EV_TO_ACTIVE  = 3'd0,
		EV_TO_PASSIVE = 3'd1,
		EV_PULSE      = 3'd2,
		EV_LONG_START = 3'd3,
		EV_LONG_END   = 3'd4
	} event_code_t;

	typedef enum logic [3:0] {
		ST_PASSIVE   = 4'b0001,
		ST_TRANSIENT = 4'b0010,
		ST_ACTIVE    = 4'b0100,
		ST_LONG      = 4'b1000
	} monitor_state_t;

	typedef struct packed {
		event_code_t code;
		logic        last;
	} evq_entry_t;

endpackage

// File: hw/rtl/pin_pulse_monitor_unit.sv
// ----------------------------------------------------------------------------
// pin_pulse_monitor_unit
// Debouncer and pulse classifier for one polled pin, with an event queue.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tdata: pin_level[0], now_ms[32:1]
//  m_*      out  m_tvalid / m_tready    m_tdata: event_code[2:0], m_tlast: last_event
//  cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_value
//
//  A poll is registered on acceptance and classified once the queue has room,
//  which writes its zero to three events into a four-entry event queue at once.
//  Polls are taken every cycle while the queue holds at most one event after
//  the current pop; the output drains one event per cycle while m_tready is high.
//  Reset (arst_n low) sets passive state, zero deadline, empty queue.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module pin_pulse_monitor_unit import ppm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // pin_level, now_ms, zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // event_code, zero pad
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_value
);

	logic [TIME_W-1:0] settle_q;
	logic [TIME_W-1:0] long_pulse_q;
	logic              active_low_q;

	logic              valid_s1;
	logic              pin_s1;
	logic [TIME_W-1:0] now_s1;

	monitor_state_t    state_q, state_d;
	logic [DL_W-1:0]   deadline_q, deadline_d;

	evq_entry_t           evq_q [EVQ_DEPTH];
	logic [EVQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [EVQ_CNT_W-1:0] count_q;

	event_code_t ev_code [MAX_EV];
	logic [1:0]  ev_n;
	logic        active;
	logic [DL_W-1:0] now_ext;
	logic        pop, room, fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q     <= SETTLE_RST;
			long_pulse_q <= LONG_PULSE_RST;
			active_low_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SETTLE:     settle_q     <= cfg_value[TIME_W-1:0];
				REG_LONG_PULSE: long_pulse_q <= cfg_value[TIME_W-1:0];
				REG_ACTIVE_LOW: active_low_q <= cfg_value[0];
				default: ;
			endcase
		end
	end

	assign pop      = m_tvalid && m_tready;
	assign room     = (count_q <= EVQ_CNT_W'(1)) || ((count_q == EVQ_CNT_W'(2)) && pop);
	assign fire     = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pin_s1 <= s_tdata[0];
			now_s1 <= s_tdata[TIME_W:1];
		end
	end

	assign active  = pin_s1 ^ active_low_q;
	assign now_ext = {1'b0, now_s1};

	always_comb begin
		state_d    = state_q;
		deadline_d = deadline_q;
		ev_n       = 2'd0;
		ev_code[0] = EV_TO_ACTIVE;
		ev_code[1] = EV_TO_PASSIVE;
		ev_code[2] = EV_PULSE;
		unique case (state_q)
			ST_PASSIVE: begin
				if (active) begin
					state_d    = ST_TRANSIENT;
					deadline_d = now_ext + {1'b0, settle_q};
				end
			end
			ST_TRANSIENT: begin
				if (now_ext >= deadline_q) begin
					if (active) begin
						ev_n       = 2'd1;
						state_d    = ST_ACTIVE;
						deadline_d = now_ext + {1'b0, long_pulse_q};
					end else begin
						ev_n    = 2'd3;
						state_d = ST_PASSIVE;
					end
				end
			end
			ST_ACTIVE: begin
				if (deadline_q < now_ext) begin
					ev_n       = 2'd1;
					ev_code[0] = EV_LONG_START;
					state_d    = ST_LONG;
				end else if (!active) begin
					ev_n       = 2'd2;
					ev_code[0] = EV_TO_PASSIVE;
					ev_code[1] = EV_PULSE;
					state_d    = ST_PASSIVE;
				end
			end
			ST_LONG: begin
				if (!active) begin
					ev_n       = 2'd2;
					ev_code[0] = EV_TO_PASSIVE;
					ev_code[1] = EV_LONG_END;
					state_d    = ST_PASSIVE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_PASSIVE;
			deadline_q <= '0;
		end else if (fire) begin
			state_q    <= state_d;
			deadline_q <= deadline_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < MAX_EV; i++) begin
				if (2'(i) < ev_n) begin
					evq_q[wr_ptr_q + EVQ_PTR_W'(i)] <= '{code: ev_code[i],
						last: (2'(i) == ev_n - 2'd1)};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + EVQ_PTR_W'(ev_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + EVQ_PTR_W'(1);
			end
			count_q <= count_q + (fire ? EVQ_CNT_W'(ev_n) : EVQ_CNT_W'(0))
				- (pop ? EVQ_CNT_W'(1) : EVQ_CNT_W'(0));
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {{(M_DATA_W-3){1'b0}}, evq_q[rd_ptr_q].code};
	assign m_tlast  = evq_q[rd_ptr_q].last;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= EVQ_CNT_W'(EVQ_DEPTH))
		else $error("event queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> ({1'b0, count_q} + {2'b0, ev_n} - {3'b0, pop}) <= 4'(EVQ_DEPTH))
		else $error("event queue overflow");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[2:0] == EV_PULSE || m_tdata[2:0] == EV_LONG_END))
		|-> m_tlast)
		else $error("pulse or long end not marked last");

	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !fire) |=> (count_q == $past(count_q) - EVQ_CNT_W'(1)))
		else $error("pop did not drain the queue");
`endif

endmodule
